/* rtl/core/id3_skip_frame_sync_finder_top_assert.svh */
// assertion macros for the tag skipper and frame sync finder
`ifndef ID3_SKIP_FRAME_SYNC_FINDER_TOP_ASSERT_SVH
`define ID3_SKIP_FRAME_SYNC_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define ID3SFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// next-cycle implication
`define ID3SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

/* rtl/core/id3sfs_pkg.sv */
package id3sfs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} byte_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] sync_offset;
		logic [31:0] tag_bytes;
	} result_item_t;

	typedef enum logic [2:0] {
		PH_TAG  = 3'd0,
		PH_SKIP = 3'd1,
		PH_HDR  = 3'd2,
		PH_SCAN = 3'd3,
		PH_WAIT = 3'd4
	} phase_t;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	localparam int WIN_DEPTH = 10;
	localparam int CNT_W     = 4;
	localparam int SKIP_W    = 30;

	// window fill levels at which a decision is taken
	localparam logic [CNT_W-1:0] IDX_LEAD_LAST = 4'd2;
	localparam logic [CNT_W-1:0] IDX_EA3_LAST  = 4'd5;
	localparam logic [CNT_W-1:0] IDX_TAG_LAST  = 4'd9;

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] SYNC_MASK   = 8'hE0;
	localparam logic [7:0] FLAG_FOOTER = 8'h10;

	localparam logic [7:0] CH_UP_I = 8'h49;
	localparam logic [7:0] CH_UP_D = 8'h44;
	localparam logic [7:0] CH_UP_E = 8'h45;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_LO_E = 8'h65;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_3    = 8'h33;

	localparam int SYNCSAFE_SHIFT = 7;
	localparam logic [SKIP_W-1:0] TAG_HDR_LEN = 30'd10;
	localparam logic [15:0]       EA3_HDR_LEN = 16'd6;

endpackage

/* rtl/core/id3sfs_parser.sv */
module id3sfs_parser import id3sfs_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  byte_item_t   item,
	output logic         res_valid,
	output result_item_t res_item
);

	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] tot_q, tot_n;
	logic [OFFSET_BITS-1:0] ofs;
	phase_t                 phase_q, phase_n;
	logic [CNT_W-1:0]       cnt_q, cnt_n;
	logic [SKIP_W-1:0]      skip_q, skip_n;
	logic                   ff_q, ff_n;
	logic [7:0]             win_q [WIN_DEPTH];
	logic                   win_we;
	logic                   found;

	logic [7:0]        b;
	logic              eof;
	logic              lead_id3, lead_ea3_lo, lead_ea3_up;
	logic              sync_lo, sync_hi, sync_scan;
	logic [SKIP_W-1:0] syncsafe, tag_skip;
	logic [15:0]       ea3_raw, ea3_len;

	assign b   = item.data_byte;
	assign eof = item.end_of_file;

	// lead-in checks use the current byte as the third one
	assign lead_id3    = (win_q[0] == CH_UP_I) && (win_q[1] == CH_UP_D) && (b == CH_3);
	assign lead_ea3_lo = (win_q[0] == CH_LO_E) && (win_q[1] == CH_LO_A) && (b == CH_3);
	assign lead_ea3_up = (win_q[0] == CH_UP_E) && (win_q[1] == CH_UP_A) && (b == CH_3);

	assign sync_lo   = (win_q[0] == SYNC_BYTE) && ((win_q[1] & SYNC_MASK) == SYNC_MASK);
	assign sync_hi   = (win_q[1] == SYNC_BYTE) && ((b & SYNC_MASK) == SYNC_MASK);
	assign sync_scan = ff_q && ((b & SYNC_MASK) == SYNC_MASK);

	assign syncsafe = (SKIP_W'(win_q[6]) << (3 * SYNCSAFE_SHIFT))
	                | (SKIP_W'(win_q[7]) << (2 * SYNCSAFE_SHIFT))
	                | (SKIP_W'(win_q[8]) << SYNCSAFE_SHIFT)
	                | SKIP_W'(b);
	assign tag_skip = syncsafe + (((win_q[5] & FLAG_FOOTER) != 8'h00) ? TAG_HDR_LEN : '0);

	assign ea3_raw = {win_q[4], b};
	assign ea3_len = (ea3_raw < EA3_HDR_LEN) ? EA3_HDR_LEN : ea3_raw;

	always_comb begin
		pos_n     = pos_q + OFFSET_BITS'(1);
		tot_n     = tot_q;
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		skip_n    = skip_q;
		ff_n      = ff_q;
		win_we    = 1'b0;
		found     = 1'b0;
		ofs       = '0;
		res_valid = 1'b0;
		res_item  = '0;

		unique case (phase_q)
			PH_TAG: begin
				win_we = (cnt_q < CNT_W'(WIN_DEPTH));
				cnt_n  = cnt_q + CNT_W'(1);
				if (cnt_q == IDX_LEAD_LAST && !lead_id3 && !lead_ea3_lo) begin
					if (lead_ea3_up) begin
						phase_n = PH_HDR;
					end else begin
						phase_n = PH_SCAN;
						ff_n    = (b == SYNC_BYTE);
						if (sync_lo) begin
							found = 1'b1;
							ofs   = pos_q - OFFSET_BITS'(2);
						end else if (sync_hi) begin
							found = 1'b1;
							ofs   = pos_q - OFFSET_BITS'(1);
						end
					end
				end else if (cnt_q == IDX_TAG_LAST) begin
					tot_n   = tot_q + OFFSET_BITS'(tag_skip + TAG_HDR_LEN);
					skip_n  = tag_skip;
					cnt_n   = '0;
					phase_n = (tag_skip == '0) ? PH_HDR : PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_n = skip_q - SKIP_W'(1);
				if (skip_q == SKIP_W'(1)) begin
					cnt_n   = '0;
					phase_n = PH_HDR;
				end
			end
			PH_HDR: begin
				win_we = 1'b1;
				cnt_n  = cnt_q + CNT_W'(1);
				if (cnt_q == IDX_LEAD_LAST && !lead_ea3_up) begin
					phase_n = PH_SCAN;
					ff_n    = (b == SYNC_BYTE);
					if (sync_lo) begin
						found = 1'b1;
						ofs   = pos_q - OFFSET_BITS'(2);
					end else if (sync_hi) begin
						found = 1'b1;
						ofs   = pos_q - OFFSET_BITS'(1);
					end
				end else if (cnt_q == IDX_EA3_LAST) begin
					tot_n   = tot_q + OFFSET_BITS'(ea3_len);
					skip_n  = SKIP_W'(ea3_len - EA3_HDR_LEN);
					cnt_n   = '0;
					phase_n = (ea3_len == EA3_HDR_LEN) ? PH_HDR : PH_SKIP;
				end
			end
			PH_SCAN: begin
				if (sync_scan) begin
					found = 1'b1;
					ofs   = pos_q - OFFSET_BITS'(1);
				end else begin
					ff_n = (b == SYNC_BYTE);
				end
			end
			PH_WAIT: begin
			end
			default: begin
			end
		endcase

		if (found) begin
			res_valid            = 1'b1;
			res_item.status      = STATUS_FOUND;
			res_item.sync_offset = 32'(ofs);
			res_item.tag_bytes   = 32'(tot_n);
			phase_n              = PH_WAIT;
		end else if (eof) begin
			res_valid            = (phase_q != PH_WAIT);
			res_item.status      = STATUS_NOT_FOUND;
			res_item.sync_offset = '0;
			res_item.tag_bytes   = 32'(tot_n);
		end

		// next file starts from scratch
		if (eof) begin
			pos_n   = '0;
			tot_n   = '0;
			phase_n = PH_TAG;
			cnt_n   = '0;
			skip_n  = '0;
			ff_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tot_q   <= '0;
			phase_q <= PH_TAG;
			cnt_q   <= '0;
			skip_q  <= '0;
			ff_q    <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			tot_q   <= tot_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			skip_q  <= skip_n;
			ff_q    <= ff_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && win_we) begin
			win_q[cnt_q] <= b;
		end
	end

endmodule

/* rtl/core/id3_skip_frame_sync_finder_top.sv */
// Tag skipper and frame sync finder for MPEG audio files.
// byte channel: byte_valid / byte_stall / byte_item, one file byte per item,
//   end_of_file set on the last byte of each file.
// result channel: result_valid / result_stall / result_item, at most one item
//   per file: status 0 with the offset of the 0xFF sync byte, or status 1 when
//   the file ends without sync; tag_bytes gives the bytes skipped as headers.
// An accepted byte goes into an input register; the parser then runs on it and,
//   when the byte advances, loads the result register with any result it gives.
//   One byte per cycle is taken while no result is held under result_stall; the
//   parser state update is the single loop that sets this.
// While a result waits under result_stall, bytes that give no result still
//   flow; a byte that would give a result is held and byte_stall rises.
// After end_of_file the parser restarts for the next file in the next cycle.
// arst_n clears the pipeline and the parser; no result is pending after it.
module id3_skip_frame_sync_finder_top import id3sfs_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  byte_item_t   byte_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item
);

	logic         valid_s1;
	byte_item_t   item_s1;
	logic         res_valid;
	result_item_t res_item;
	logic         out_free;
	logic         advance;
	logic         result_valid_q;
	result_item_t result_q;

	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && (!res_valid || out_free);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	id3sfs_parser #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.res_valid(res_valid),
		.res_item (res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			result_valid_q <= 1'b1;
		end else if (out_free) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res_item;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

/* rtl/core/id3sfs_checker.sv */
`include "id3_skip_frame_sync_finder_top_assert.svh"

module id3sfs_checker import id3sfs_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         byte_stall,
	input logic         result_valid,
	input logic         result_stall,
	input result_item_t result_item
);

	`ID3SFS_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)
	`ID3SFS_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && result_stall, $stable(result_item))
	`ID3SFS_ASSERT_IMPL(a_stall_cause, clk, arst_n, byte_stall, result_valid && result_stall)
	`ID3SFS_ASSERT_IMPL(a_miss_offset, clk, arst_n, result_valid && (result_item.status == STATUS_NOT_FOUND), result_item.sync_offset == '0)

endmodule

bind id3_skip_frame_sync_finder_top id3sfs_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_stall  (byte_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_item (result_item)
);

/* tb/tb_top.sv */
module tb_top;
	import id3sfs_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	logic         byte_stall;
	byte_item_t   byte_item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;

	id3_skip_frame_sync_finder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	always #5 clk = ~clk;

	// parser state as the block should hold it
	logic [31:0] pos;
	logic [7:0]  win [WIN_DEPTH];
	int          wcnt;
	phase_t      phase;
	logic [63:0] skip_rem;
	logic [31:0] skipped;
	logic        prev_ff;
	logic        hit;
	logic [31:0] hit_ofs;

	byte_item_t   file_bytes_due[$];
	result_item_t sync_reports_due[$];
	logic [7:0]   draft[$];

	int errors = 0;
	int files_sent = 0;
	int syncs_seen = 0;
	int misses_seen = 0;
	int in_gap = 0;
	int stall_left = 0;
	logic calm = 1'b0;
	logic in_acc = 1'b0;

	task automatic restart_parse();
		pos = '0;
		for (int i = 0; i < WIN_DEPTH; i++)
			win[i] = '0;
		wcnt = 0;
		phase = PH_TAG;
		skip_rem = '0;
		skipped = '0;
		prev_ff = 1'b0;
	endtask

	function automatic logic win_is(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return win[0] == a && win[1] == b && win[2] == c;
	endfunction

	task automatic start_skip(input logic [63:0] n);
		skip_rem = n;
		wcnt = 0;
		phase = (n != 0) ? PH_SKIP : PH_HDR;
	endtask

	task automatic scan_one(input logic [7:0] b, input logic [31:0] at);
		if (!hit) begin
			if (prev_ff && (b & SYNC_MASK) == SYNC_MASK) begin
				hit = 1'b1;
				hit_ofs = at - 32'd1;
			end else begin
				prev_ff = (b == SYNC_BYTE);
			end
		end
	endtask

	// at a scan start: either an EA3 header to skip or the first bytes to scan
	task automatic look_for_ea3();
		logic [31:0] first;
		logic [63:0] amt;
		if (!win_is(CH_UP_E, CH_UP_A, CH_3)) begin
			first = pos - wcnt;
			phase = PH_SCAN;
			prev_ff = 1'b0;
			for (int i = 0; i < wcnt && i < WIN_DEPTH; i++)
				scan_one(win[i], first + i);
		end else if (wcnt >= int'(IDX_EA3_LAST) + 1) begin
			amt = {win[4], win[5]};
			if (amt < EA3_HDR_LEN)
				amt = EA3_HDR_LEN;
			skipped = skipped + amt[31:0];
			start_skip(amt - EA3_HDR_LEN);
		end
	endtask

	task automatic parse_byte(input byte_item_t it);
		logic [7:0]  b;
		logic [31:0] at;
		logic [63:0] sz;
		result_item_t rep;
		b = it.data_byte;
		at = pos;
		hit = 1'b0;
		hit_ofs = '0;
		pos = pos + 32'd1;
		case (phase)
			PH_TAG: begin
				if (wcnt < WIN_DEPTH) begin
					win[wcnt] = b;
					wcnt++;
				end
				if (wcnt == int'(IDX_LEAD_LAST) + 1 && !win_is(CH_UP_I, CH_UP_D, CH_3)
						&& !win_is(CH_LO_E, CH_LO_A, CH_3)) begin
					phase = PH_HDR;
					look_for_ea3();
				end else if (wcnt >= WIN_DEPTH) begin
					sz = win[6];
					sz = (sz << SYNCSAFE_SHIFT) | win[7];
					sz = (sz << SYNCSAFE_SHIFT) | win[8];
					sz = (sz << SYNCSAFE_SHIFT) | win[9];
					sz = sz + TAG_HDR_LEN;
					if ((win[5] & FLAG_FOOTER) != 0)
						sz = sz + TAG_HDR_LEN;
					skipped = skipped + sz[31:0];
					start_skip(sz - TAG_HDR_LEN);
				end
			end
			PH_SKIP: begin
				if (skip_rem != 0)
					skip_rem = skip_rem - 1;
				if (skip_rem == 0) begin
					wcnt = 0;
					phase = PH_HDR;
				end
			end
			PH_HDR: begin
				if (wcnt < WIN_DEPTH) begin
					win[wcnt] = b;
					wcnt++;
				end
				if (wcnt == int'(IDX_LEAD_LAST) + 1 || wcnt == int'(IDX_EA3_LAST) + 1)
					look_for_ea3();
			end
			PH_SCAN: scan_one(b, at);
			default: ;
		endcase
		if (hit) begin
			rep.status = STATUS_FOUND;
			rep.sync_offset = hit_ofs;
			rep.tag_bytes = skipped;
			sync_reports_due.push_back(rep);
			if (it.end_of_file)
				restart_parse();
			else
				phase = PH_WAIT;
		end else if (it.end_of_file) begin
			if (phase != PH_WAIT) begin
				rep.status = STATUS_NOT_FOUND;
				rep.sync_offset = '0;
				rep.tag_bytes = skipped;
				sync_reports_due.push_back(rep);
			end
			restart_parse();
		end
	endtask

	// stimulus building
	task automatic put(input logic [7:0] b);
		draft.push_back(b);
	endtask

	task automatic ship();
		byte_item_t it;
		for (int i = 0; i < draft.size(); i++) begin
			it.data_byte = draft[i];
			it.end_of_file = (i == draft.size() - 1);
			file_bytes_due.push_back(it);
		end
		draft.delete();
		files_sent++;
	endtask

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 3))
			0: return SYNC_BYTE;
			1: return 8'($urandom) | SYNC_MASK;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic draft_random_file();
		int lead, n, fill, amt;
		logic [7:0] flags, hi, lo;
		logic cut_short;
		cut_short = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			// plain noise
			n = $urandom_range(1, 20);
			repeat (n) put(8'($urandom));
		end else begin
			lead = $urandom_range(0, 4);
			if (lead < 3) begin
				if (lead == 0) begin
					put(CH_LO_E); put(CH_LO_A); put(CH_3);
				end else begin
					put(CH_UP_I); put(CH_UP_D); put(CH_3);
				end
				put(8'($urandom));
				put(8'($urandom));
				flags = 8'($urandom);
				if ($urandom_range(0, 1) == 0)
					flags = flags & ~FLAG_FOOTER;
				put(flags);
				if ($urandom_range(0, 7) == 0) begin
					repeat (4) put(8'($urandom));
					cut_short = 1'b1;
				end else begin
					hi = ($urandom_range(0, 9) == 0) ? 8'd1 : 8'd0;
					lo = 8'($urandom_range(0, 40));
					put(8'h00); put(8'h00); put(hi); put(lo);
					fill = (int'(hi) << SYNCSAFE_SHIFT) + int'(lo)
						+ (((flags & FLAG_FOOTER) != 0) ? int'(TAG_HDR_LEN) : 0);
					repeat (fill) put(8'($urandom));
				end
			end
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
			for (int k = 0; k < n && !cut_short; k++) begin
				put(CH_UP_E); put(CH_UP_A); put(CH_3);
				put(8'($urandom));
				if ($urandom_range(0, 7) == 0) begin
					put(8'($urandom)); put(8'($urandom));
					cut_short = 1'b1;
				end else begin
					amt = $urandom_range(0, 24);
					put(8'h00); put(8'(amt));
					fill = (amt > int'(EA3_HDR_LEN)) ? amt - int'(EA3_HDR_LEN) : 0;
					repeat (fill) put(8'($urandom));
				end
			end
			if (cut_short) begin
				n = $urandom_range(0, 8);
				repeat (n) put(8'($urandom));
			end else begin
				n = $urandom_range(0, 30);
				repeat (n) put(body_byte());
				if ($urandom_range(0, 2) != 0) begin
					put(SYNC_BYTE);
					put(8'($urandom) | SYNC_MASK);
				end
				n = $urandom_range(0, 6);
				repeat (n) put(body_byte());
			end
			// broken file: cut anywhere
			if ($urandom_range(0, 9) == 0 && draft.size() > 1) begin
				n = $urandom_range(1, draft.size() - 1);
				while (draft.size() > n)
					void'(draft.pop_back());
			end
		end
		if (draft.size() == 0)
			put(8'($urandom));
		ship();
	endtask

	// byte driver
	always @(negedge clk) begin : drive
		logic       nv;
		byte_item_t ni;
		nv = byte_valid;
		ni = byte_item;
		if (arst_n) begin
			if ($urandom_range(0, 249) == 0)
				calm <= ~calm;
			if (in_acc)
				nv = 1'b0;
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (file_bytes_due.size() > 0) begin
					if (!calm && file_bytes_due.size() > 200 && $urandom_range(0, 9) == 0) begin
						in_gap = $urandom_range(1, 17) - 1;
					end else begin
						ni = file_bytes_due.pop_front();
						nv = 1'b1;
					end
				end
			end
		end
		byte_valid <= nv;
		byte_item <= ni;
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!calm && file_bytes_due.size() > 200 && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 17) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		result_item_t want;
		in_acc <= arst_n && byte_valid && !byte_stall;
		if (arst_n && byte_valid && !byte_stall)
			parse_byte(byte_item);
		if (arst_n && result_valid && !result_stall) begin
			if (sync_reports_due.size() == 0) begin
				$error("result with none expected: status %0d offset %0d tag bytes %0d",
					result_item.status, result_item.sync_offset, result_item.tag_bytes);
				errors++;
			end else begin
				want = sync_reports_due.pop_front();
				if (want.status == STATUS_FOUND)
					syncs_seen++;
				else
					misses_seen++;
				if (result_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_item.status);
					errors++;
				end
				if (result_item.sync_offset !== want.sync_offset) begin
					$error("sync_offset: expected %0d, got %0d", want.sync_offset,
						result_item.sync_offset);
					errors++;
				end
				if (result_item.tag_bytes !== want.tag_bytes) begin
					$error("tag_bytes: expected %0d, got %0d", want.tag_bytes,
						result_item.tag_bytes);
					errors++;
				end
			end
		end
	end

	initial begin
		int sent;
		restart_parse();
		// single 0xff as the whole file
		put(SYNC_BYTE);
		ship();
		// sync inside the first window, found on the marked last byte
		put(8'h00); put(SYNC_BYTE); put(SYNC_MASK);
		ship();
		// short ea3 skip raised to the header length, then a short scan start
		put(CH_UP_E); put(CH_UP_A); put(CH_3); put(8'h7F); put(8'h00); put(8'h02);
		put(SYNC_BYTE);
		ship();
		// empty ea3 tag, sync straight after, the rest of the file ignored
		put(CH_LO_E); put(CH_LO_A); put(CH_3);
		repeat (7) put(8'h00);
		put(SYNC_BYTE); put(8'hF1); put(8'h00); put(SYNC_BYTE);
		ship();
		while (file_bytes_due.size() < 1750)
			draft_random_file();
		sent = file_bytes_due.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (file_bytes_due.size() != 0 || byte_valid)
			@(posedge clk);
		while (sync_reports_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d bytes in %0d files sent, with ID3, ea3 and EA3 headers, truncations and noise",
			sent, files_sent);
		$display("results checked: %0d with frame sync, %0d without", syncs_seen, misses_seen);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/id3sfs_pkg.sv
rtl/core/id3sfs_parser.sv
rtl/core/id3_skip_frame_sync_finder_top.sv
rtl/core/id3sfs_checker.sv
tb/tb_top.sv
